FILE: rtl/core/overwriting_message_ring_queue_unit_macros.svh
// assertion macros shared by the ring queue rtl
// depends on nothing; expects clk and rst_n in the including module
`ifndef OVERWRITING_MESSAGE_RING_QUEUE_UNIT_MACROS_SVH
`define OVERWRITING_MESSAGE_RING_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define ORMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ORMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ormq_pkg.sv
// package for the overwriting message ring queue
// sizes, action codes, controller state type and slot and byte address helpers; no dependencies
package ormq_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int MESSAGE_BYTES = 64;
    localparam int SLOT_COUNT    = QUEUE_DEPTH + 1;
    localparam int BYTE_DEPTH    = SLOT_COUNT * MESSAGE_BYTES;

    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W       = $clog2(MESSAGE_BYTES + 1);
    localparam int BYTE_ADDR_W = $clog2(BYTE_DEPTH);
    localparam int LEFT_W      = 4;
    localparam int ACTION_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMMIT  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_STREAM
    } state_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(SLOT_COUNT - 1))
            return '0;
        return s + SLOT_W'(1);
    endfunction

    function automatic logic [BYTE_ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                         input logic [LEN_W-1:0]  k);
        return BYTE_ADDR_W'(BYTE_ADDR_W'(s) * BYTE_ADDR_W'(MESSAGE_BYTES))
               + BYTE_ADDR_W'(k);
    endfunction

endpackage

FILE: rtl/core/ormq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies; read data holds while no read is enabled
module ormq_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/overwriting_message_ring_queue_unit.sv
// Ring queue of up to QUEUE_DEPTH messages of up to MESSAGE_BYTES bytes, one byte per
// input item; a commit on a full queue drops the oldest message, so a commit is never
// refused. A dequeue is accepted in ST_IDLE, reads the length memory in ST_LEN, then in
// ST_STREAM issues the byte reads in order through the single read port of the byte
// memory (an item with no byte for an empty message), waiting while the pending stage
// cannot move; input is held off until the last byte read is issued, while results drain
// through that stage and an output register. A dequeue on an empty queue gives no result.
// depends on ormq_pkg, ormq_ram and overwriting_message_ring_queue_unit_macros.svh
`include "overwriting_message_ring_queue_unit_macros.svh"

module overwriting_message_ring_queue_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ormq_pkg::ACTION_W-1:0]  action,
    input  logic [7:0]                     data_byte,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           byte_valid,
    output logic                           end_of_message,
    output logic [ormq_pkg::LEFT_W-1:0]    messages_left
);
    import ormq_pkg::*;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0] dslot_reg, dslot_next;
    logic [LEFT_W-1:0] dleft_reg, dleft_next;
    logic [LEN_W-1:0]  dlen_reg, dlen_next;
    logic [LEN_W-1:0]  k_reg, k_next;

    logic              pend_reg, pend_next;
    logic              pend_bv_reg, pend_bv_next;
    logic              pend_eom_reg, pend_eom_next;
    logic [LEFT_W-1:0] pend_left_reg, pend_left_next;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              byte_valid_reg;
    logic              eom_reg;
    logic [LEFT_W-1:0] out_left_reg;

    logic                   byte_we, byte_re;
    logic [BYTE_ADDR_W-1:0] byte_waddr, byte_raddr;
    logic [7:0]             byte_rdata;
    logic                   len_we, len_re;
    logic [LEN_W-1:0]       len_wdata, len_rdata;

    logic accept, move, can_issue, commit;
    logic [LEN_W-1:0] fill_inc;

    ormq_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (data_byte),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    ormq_ram #(.WIDTH(LEN_W), .DEPTH(SLOT_COUNT)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (wslot_reg),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (rslot_reg),
        .rdata (len_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign move      = pend_reg && (!out_valid_reg || out_ready);
    assign can_issue = !pend_reg || move;
    assign fill_inc  = fill_reg + LEN_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        wslot_next     = wslot_reg;
        rslot_next     = rslot_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        dslot_next     = dslot_reg;
        dleft_next     = dleft_reg;
        dlen_next      = dlen_reg;
        k_next         = k_reg;
        pend_next      = pend_reg && !move;
        pend_bv_next   = pend_bv_reg;
        pend_eom_next  = pend_eom_reg;
        pend_left_next = pend_left_reg;
        byte_we        = 1'b0;
        byte_waddr     = byte_addr(wslot_reg, fill_reg);
        byte_re        = 1'b0;
        byte_raddr     = byte_addr(dslot_reg, k_reg);
        len_we         = 1'b0;
        len_wdata      = fill_reg;
        len_re         = 1'b0;
        commit         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_PUSH:
                        begin
                            if (fill_reg < LEN_W'(MESSAGE_BYTES))
                            begin
                                byte_we   = 1'b1;
                                fill_next = fill_inc;
                                len_wdata = fill_inc;
                            end
                            commit = last;
                        end
                        ACT_COMMIT:
                        begin
                            commit = 1'b1;
                        end
                        ACT_DEQUEUE:
                        begin
                            if (count_reg != '0)
                            begin
                                len_re     = 1'b1;
                                dslot_next = rslot_reg;
                                dleft_next = LEFT_W'(count_reg - CNT_W'(1));
                                rslot_next = next_slot(rslot_reg);
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_LEN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (commit)
                begin
                    len_we     = 1'b1;
                    wslot_next = next_slot(wslot_reg);
                    fill_next  = '0;
                    if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        rslot_next = next_slot(rslot_reg);
                    else
                        count_next = count_reg + CNT_W'(1);
                end
            end
            ST_LEN:
            begin
                dlen_next  = len_rdata;
                k_next     = '0;
                state_next = ST_STREAM;
            end
            ST_STREAM:
            begin
                if (can_issue)
                begin
                    pend_next      = 1'b1;
                    pend_left_next = dleft_reg;
                    if (dlen_reg == '0)
                    begin
                        pend_bv_next  = 1'b0;
                        pend_eom_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        byte_re       = 1'b1;
                        pend_bv_next  = 1'b1;
                        pend_eom_next = (k_reg + LEN_W'(1) == dlen_reg);
                        k_next        = k_reg + LEN_W'(1);
                        if (k_reg + LEN_W'(1) == dlen_reg)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wslot_reg <= wslot_next;
            rslot_reg <= rslot_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dslot_reg     <= dslot_next;
        dleft_reg     <= dleft_next;
        dlen_reg      <= dlen_next;
        k_reg         <= k_next;
        pend_bv_reg   <= pend_bv_next;
        pend_eom_reg  <= pend_eom_next;
        pend_left_reg <= pend_left_next;
        if (move)
        begin
            out_byte_reg   <= pend_bv_reg ? byte_rdata : 8'd0;
            byte_valid_reg <= pend_bv_reg;
            eom_reg        <= pend_eom_reg;
            out_left_reg   <= pend_left_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign end_of_message = eom_reg;
    assign messages_left  = out_left_reg;

    `ORMQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "count overflow")
    `ORMQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= LEN_W'(MESSAGE_BYTES), "fill overflow")
    `ORMQ_ASSERT_NOW(a_empty_is_end, out_valid_reg && !byte_valid_reg, eom_reg,
                     "empty item without end of message")
    `ORMQ_ASSERT_NEXT(a_deq_empty_idle,
                      accept && action == ACT_DEQUEUE && count_reg == '0,
                      state_reg == ST_IDLE, "dequeue on empty queue left idle")
    `ORMQ_ASSERT_NEXT(a_pend_hold, pend_reg && !move, pend_reg, "pending item lost")

endmodule

FILE: sim/tb_overwriting_message_ring_queue_unit.sv
// testbench for overwriting_message_ring_queue_unit: a directed table, then random messages,
// dequeues and noise, checked item by item against a behavioral queue model or table values
// depends on ormq_pkg and the overwriting_message_ring_queue_unit rtl
module tb_overwriting_message_ring_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ormq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 75;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 150;
    localparam int DIRECTED_ROWS   = 21;

    typedef struct packed {
        logic [7:0]        data;
        logic              has_data;
        logic              eom;
        logic [LEFT_W-1:0] left;
    } msg_result_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } row_check_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [7:0]          data;
        logic                last;
        logic [7:0]          reps;
        row_check_t          chk;
        msg_result_t         want;
    } stim_row_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [ACTION_W-1:0] action         = ACT_PUSH;
    logic [7:0]          data_byte      = 8'h00;
    logic                last           = 1'b0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                end_of_message;
    logic [LEFT_W-1:0]   messages_left;

    // queue model state
    logic [7:0]       model_bytes [SLOT_COUNT][MESSAGE_BYTES];
    logic [LEN_W-1:0] model_len [SLOT_COUNT];
    logic [SLOT_W-1:0] model_wr_slot = '0;
    logic [SLOT_W-1:0] model_rd_slot = '0;
    int unsigned       model_count   = 0;
    int unsigned       model_fill    = 0;

    msg_result_t step_results[$];
    msg_result_t expected_results[$];

    int unsigned fail_count    = 0;
    int unsigned quiet_cycles  = 0;
    bit          tx_calm       = 1'b0;
    bit          rx_calm       = 1'b0;
    bit          hold_off_req  = 1'b0;
    bit          hold_off_done = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_NONE,  '0},
        '{ACT_COMMIT,  8'h00, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_ONE,   '{8'h00, 1'b0, 1'b1, 4'd0}},
        '{ACT_PUSH,    8'h00, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_PUSH,    8'hFF, 1'b1, 8'd1,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_UNUSED,  8'hA5, 1'b1, 8'd1,  CHK_NONE,  '0},
        '{ACT_PUSH,    8'h5A, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_NONE,  '0},
        '{ACT_PUSH,    8'h81, 1'b1, 8'd1,  CHK_MODEL, '0},
        '{ACT_PUSH,    8'h12, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_COMMIT,  8'hFF, 1'b1, 8'd1,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'hFF, 1'b1, 8'd1,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_PUSH,    8'h00, 1'b0, 8'd70, CHK_MODEL, '0},
        '{ACT_PUSH,    8'h77, 1'b1, 8'd1,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_MODEL, '0},
        '{ACT_COMMIT,  8'h00, 1'b0, 8'd3,  CHK_MODEL, '0},
        '{ACT_PUSH,    8'h3C, 1'b1, 8'd7,  CHK_MODEL, '0},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd1,  CHK_ONE,   '{8'h00, 1'b0, 1'b1, 4'd7}},
        '{ACT_DEQUEUE, 8'h00, 1'b0, 8'd8,  CHK_MODEL, '0}
    };

    overwriting_message_ring_queue_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .data_byte      (data_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .messages_left  (messages_left)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [SLOT_W-1:0] bump_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic void commit_model_message();
        model_len[model_wr_slot] = LEN_W'(model_fill);
        model_wr_slot = bump_slot(model_wr_slot);
        if (model_count >= QUEUE_DEPTH)
            model_rd_slot = bump_slot(model_rd_slot);
        else
            model_count++;
        model_fill = 0;
    endfunction

    function automatic void predict_queue_item(input logic [ACTION_W-1:0] a,
                                               input logic [7:0] d, input logic l);
        msg_result_t r;
        int unsigned n;
        step_results.delete();
        case (a)
            ACT_PUSH:
            begin
                if (model_fill < MESSAGE_BYTES)
                begin
                    model_bytes[model_wr_slot][model_fill] = d;
                    model_fill++;
                end
                if (l)
                    commit_model_message();
            end
            ACT_COMMIT:
                commit_model_message();
            ACT_DEQUEUE:
            begin
                if (model_count != 0)
                begin
                    n = model_len[model_rd_slot];
                    r.left = LEFT_W'(model_count - 1);
                    if (n == 0)
                    begin
                        r.data = 8'h00;
                        r.has_data = 1'b0;
                        r.eom = 1'b1;
                        step_results.push_back(r);
                    end
                    for (int k = 0; k < n; k++)
                    begin
                        r.data = model_bytes[model_rd_slot][k];
                        r.has_data = 1'b1;
                        r.eom = (k == n - 1);
                        step_results.push_back(r);
                    end
                    model_rd_slot = bump_slot(model_rd_slot);
                    model_count--;
                end
            end
            default:
                ;
        endcase
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] a, input logic [7:0] d,
                             input logic l, input row_check_t chk, input msg_result_t want);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= a;
        data_byte <= d;
        last      <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_queue_item(a, d, l);
        case (chk)
            CHK_MODEL:
                foreach (step_results[i])
                    expected_results.push_back(step_results[i]);
            CHK_ONE:
                expected_results.push_back(want);
            default:
                ;
        endcase
    endtask

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned msg_len;
        int unsigned pick;
        bit          end_with_last;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (int i = 0; i < directed_rows[r].reps; i++)
                send_item(directed_rows[r].act, directed_rows[r].data + 8'(i),
                          directed_rows[r].last, directed_rows[r].chk, directed_rows[r].want);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= 40 && !hold_off_done)
            begin
                hold_off_req  = 1'b1;
                hold_off_done = 1'b1;
            end
            if ($urandom_range(0, 29) == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                msg_len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(0, 6);
                end_with_last = (msg_len != 0) && ($urandom_range(0, 3) != 0);
                for (int k = 0; k < msg_len; k++)
                    send_item(ACT_PUSH, 8'($urandom), end_with_last && (k == msg_len - 1),
                              CHK_MODEL, '0);
                if (!end_with_last)
                    send_item(ACT_COMMIT, 8'($urandom), 1'($urandom), CHK_MODEL, '0);
                random_items += msg_len + (end_with_last ? 0 : 1);
            end
            else if (pick < 85)
            begin
                send_item(ACT_DEQUEUE, 8'($urandom), 1'($urandom), CHK_MODEL, '0);
                random_items++;
            end
            else if (pick < 92)
            begin
                send_item(ACT_UNUSED, 8'($urandom), 1'($urandom), CHK_MODEL, '0);
                random_items++;
            end
            else
            begin
                send_item($urandom_range(0, 1) ? ACT_PUSH : ACT_COMMIT, 8'($urandom),
                          1'($urandom), CHK_MODEL, '0);
                random_items++;
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[overwriting_message_ring_queue_unit] OK");
        else
            $display("[overwriting_message_ring_queue_unit] ERROR");
        $finish;
    end

    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            stall = pick_gap(rx_calm);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        msg_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected item: out_byte %02h end_of_message %0b", out_byte,
                       end_of_message);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    fail_count++;
                end
                if (byte_valid !== want.has_data)
                begin
                    $error("byte_valid: expected %0b, got %0b", want.has_data, byte_valid);
                    fail_count++;
                end
                if (end_of_message !== want.eom)
                begin
                    $error("end_of_message: expected %0b, got %0b", want.eom,
                           end_of_message);
                    fail_count++;
                end
                if (messages_left !== want.left)
                begin
                    $error("messages_left: expected %0d, got %0d", want.left,
                           messages_left);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[overwriting_message_ring_queue_unit] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
